/* rtl/dasp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dasp_pkg
// Shared types and constants for the dual-axis slew positioner.
// ----------------------------------------------------------------------------
package dasp_pkg;

  localparam int AZ_W    = 16;
  localparam int EL_W    = 14;
  localparam int SPEED_W = 16;
  localparam int MS_W    = 16;
  localparam int PROD_W  = SPEED_W + MS_W;
  localparam int STEP_W  = 23;

  // floor(p / 1000) = floor((p >> 3) * RECIP >> 36) for any 32-bit p
  localparam int DIV1000_PRE   = 3;
  localparam int DIV1000_SHIFT = 36;
  localparam int RECIP_W       = 30;
  localparam int QUOT_W        = PROD_W - DIV1000_PRE + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV1000_RECIP = 30'd549755814;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd1000;

  localparam logic CFG_AZ_SPEED = 1'b0;
  localparam logic CFG_EL_SPEED = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_ORIENT = 3'd1,
    CMD_JOG_AZ = 3'd2,
    CMD_JOG_EL = 3'd3,
    CMD_STOP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EL   = 2'd1,
    PH_AZ   = 2'd2
  } phase_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [15:0]        az_target;
    logic signed [15:0] el_target;
    logic signed [16:0] delta;
  } item_t;

  typedef struct packed {
    logic            user_stopped;
    phase_t          phase;
    logic            el_busy;
    logic            az_busy;
    logic [EL_W-1:0] el_pos;
    logic [AZ_W-1:0] az_pos;
  } res_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic out_load;
  } pipe_ctl_t;

endpackage
`default_nettype wire

/* rtl/dasp_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dasp_step
// Two-stage slew step: speed * ms, then divide by 1000 via reciprocal.
// ----------------------------------------------------------------------------
module dasp_step import dasp_pkg::*; (
  input  wire logic               clk,
  input  wire pipe_ctl_t          ctl,
  input  wire logic [SPEED_W-1:0] speed,
  input  wire logic [MS_W-1:0]    ms,
  output logic      [STEP_W-1:0]  step
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [QUOT_W-1:0] quot;
  logic [STEP_W-1:0] step_r;

  assign prod_nxt = speed * ms;
  assign quot     = prod_r[PROD_W-1:DIV1000_PRE] * DIV1000_RECIP;

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      prod_r <= prod_nxt;
    end
    if (ctl.s2_load) begin
      step_r <= quot[DIV1000_SHIFT +: STEP_W];
    end
  end

  assign step = step_r;

endmodule
`default_nettype wire

/* rtl/dasp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dasp_core
// Positioner state update and result register.
// ----------------------------------------------------------------------------
module dasp_core import dasp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pipe_ctl_t         ctl,
  input  wire item_t             item,
  input  wire logic [STEP_W-1:0] az_step,
  input  wire logic [STEP_W-1:0] el_step,
  input  wire logic              out_tready,
  output logic                   out_valid,
  output res_t                   res
);

  logic [AZ_W-1:0] az_now_r, az_now_nxt, az_goal_r, az_goal_nxt;
  logic [AZ_W-1:0] pend_az_r, pend_az_nxt;
  logic [EL_W-1:0] el_now_r, el_now_nxt, el_goal_r, el_goal_nxt;
  logic [EL_W-1:0] pend_el_r, pend_el_nxt;
  logic            az_mov_r, az_mov_nxt, el_mov_r, el_mov_nxt;
  logic            stop_r, stop_nxt;
  phase_t          phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r;

  // shortest wrapped distance goal - now, in -18000..18000
  function automatic logic signed [15:0] az_wrap(input logic [AZ_W-1:0] goal,
                                                 input logic [AZ_W-1:0] now);
    logic signed [17:0] d;
    d = $signed({2'b00, goal}) - $signed({2'b00, now});
    if (d > 18'sd18000) begin
      d = d - 18'sd36000;
    end else if (d < -18'sd18000) begin
      d = d + 18'sd36000;
    end
    return d[15:0];
  endfunction

  // reduce -72000..107999 into 0..35999
  function automatic logic [AZ_W-1:0] az_mod(input logic signed [17:0] s);
    logic signed [17:0] r;
    if (s < -18'sd36000) begin
      r = s + 18'sd72000;
    end else if (s < 18'sd0) begin
      r = s + 18'sd36000;
    end else if (s >= 18'sd72000) begin
      r = s - 18'sd72000;
    end else if (s >= 18'sd36000) begin
      r = s - 18'sd36000;
    end else begin
      r = s;
    end
    return r[AZ_W-1:0];
  endfunction

  function automatic logic [EL_W-1:0] el_clamp(input logic signed [17:0] e);
    logic [EL_W-1:0] r;
    if (e < 18'sd0) begin
      r = '0;
    end else if (e > 18'sd9000) begin
      r = EL_W'(9000);
    end else begin
      r = e[EL_W-1:0];
    end
    return r;
  endfunction

  logic signed [15:0] az_d, az_d2;
  logic [14:0]        az_mag;
  logic signed [17:0] az_n;
  logic [AZ_W-1:0]    az_tick;
  logic               az_snap;
  logic signed [14:0] el_d;
  logic [13:0]        el_mag;
  logic signed [17:0] el_n;
  logic [EL_W-1:0]    el_tick;
  logic               el_snap;
  logic [AZ_W-1:0]    base_az, jog_az, ori_az;
  logic [EL_W-1:0]    base_el, jog_el, ori_el;
  logic signed [17:0] delta_x;

  // tick motion, azimuth
  always_comb begin
    az_d    = az_wrap(az_goal_r, az_now_r);
    az_mag  = az_d[15] ? 15'(-az_d) : az_d[14:0];
    az_snap = ({8'b0, az_mag} <= az_step);
    if (az_d > 16'sd0) begin
      az_n = $signed({2'b00, az_now_r}) + $signed({3'b000, az_step[14:0]});
    end else begin
      az_n = $signed({2'b00, az_now_r}) - $signed({3'b000, az_step[14:0]});
    end
    if (az_snap) begin
      az_tick = az_goal_r;
    end else if (az_n < 18'sd0) begin
      az_tick = AZ_W'(az_n + 18'sd36000);
    end else if (az_n >= 18'sd36000) begin
      az_tick = AZ_W'(az_n - 18'sd36000);
    end else begin
      az_tick = az_n[AZ_W-1:0];
    end
  end

  // tick motion, elevation
  always_comb begin
    el_d    = $signed({1'b0, el_goal_r}) - $signed({1'b0, el_now_r});
    el_mag  = el_d[14] ? 14'(-el_d) : el_d[13:0];
    el_snap = ({9'b0, el_mag} <= el_step);
    if (el_d > 15'sd0) begin
      el_n = $signed({4'b0000, el_now_r}) + $signed({4'b0000, el_step[13:0]});
    end else begin
      el_n = $signed({4'b0000, el_now_r}) - $signed({4'b0000, el_step[13:0]});
    end
    el_tick = el_snap ? el_goal_r : el_clamp(el_n);
  end

  // orient and jog targets
  always_comb begin
    base_az = (phase_r != PH_IDLE) ? pend_az_r : az_now_r;
    base_el = (phase_r != PH_IDLE) ? pend_el_r : el_now_r;
    delta_x = {item.delta[16], item.delta};
    jog_az  = az_mod($signed({2'b00, base_az}) + delta_x);
    jog_el  = el_clamp($signed({4'b0000, base_el}) + delta_x);
    ori_az  = az_mod($signed({2'b00, item.az_target}));
    ori_el  = el_clamp({{2{item.el_target[15]}}, item.el_target});
  end

  // distance at azimuth start, taken after this tick's motion
  assign az_d2 = az_wrap(pend_az_r, az_tick);

  always_comb begin
    az_now_nxt  = az_now_r;
    az_goal_nxt = az_goal_r;
    pend_az_nxt = pend_az_r;
    el_now_nxt  = el_now_r;
    el_goal_nxt = el_goal_r;
    pend_el_nxt = pend_el_r;
    az_mov_nxt  = az_mov_r;
    el_mov_nxt  = el_mov_r;
    stop_nxt    = stop_r;
    phase_nxt   = phase_r;
    case (item.cmd)
      CMD_TICK: begin
        az_now_nxt = az_tick;
        el_now_nxt = el_tick;
        if (az_snap) begin
          az_mov_nxt = 1'b0;
        end
        if (el_snap) begin
          el_mov_nxt = 1'b0;
        end
        case (phase_r)
          PH_EL: begin
            if (el_snap || !el_mov_r) begin
              stop_nxt    = 1'b0;
              az_goal_nxt = pend_az_r;
              phase_nxt   = PH_AZ;
              if (az_d2 <= 16'sd5 && az_d2 >= -16'sd5) begin
                az_now_nxt = pend_az_r;
                az_mov_nxt = 1'b0;
              end else begin
                az_mov_nxt = 1'b1;
              end
            end
          end
          PH_AZ: begin
            if (az_snap || !az_mov_r) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      CMD_ORIENT, CMD_JOG_AZ, CMD_JOG_EL: begin
        stop_nxt   = 1'b0;
        el_mov_nxt = 1'b1;
        phase_nxt  = PH_EL;
        case (item.cmd)
          CMD_ORIENT: begin
            pend_az_nxt = ori_az;
            pend_el_nxt = ori_el;
          end
          CMD_JOG_AZ: begin
            pend_az_nxt = jog_az;
            pend_el_nxt = base_el;
          end
          default: begin
            pend_az_nxt = base_az;
            pend_el_nxt = jog_el;
          end
        endcase
        el_goal_nxt = pend_el_nxt;
      end
      CMD_STOP: begin
        stop_nxt    = 1'b1;
        az_mov_nxt  = 1'b0;
        el_mov_nxt  = 1'b0;
        phase_nxt   = PH_IDLE;
        az_goal_nxt = az_now_r;
        el_goal_nxt = el_now_r;
      end
      default: ;
    endcase
  end

  // hold the result until taken
  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_now_r    <= '0;
      az_goal_r   <= '0;
      pend_az_r   <= '0;
      el_now_r    <= '0;
      el_goal_r   <= '0;
      pend_el_r   <= '0;
      az_mov_r    <= 1'b0;
      el_mov_r    <= 1'b0;
      stop_r      <= 1'b0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctl.out_load) begin
        az_now_r  <= az_now_nxt;
        az_goal_r <= az_goal_nxt;
        pend_az_r <= pend_az_nxt;
        el_now_r  <= el_now_nxt;
        el_goal_r <= el_goal_nxt;
        pend_el_r <= pend_el_nxt;
        az_mov_r  <= az_mov_nxt;
        el_mov_r  <= el_mov_nxt;
        stop_r    <= stop_nxt;
        phase_r   <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_r.az_pos       <= az_now_nxt;
      res_r.el_pos       <= el_now_nxt;
      res_r.az_busy      <= az_mov_nxt;
      res_r.el_busy      <= el_mov_nxt;
      res_r.phase        <= phase_nxt;
      res_r.user_stopped <= stop_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

/* rtl/dual_axis_slew_positioner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dual_axis_slew_positioner
// Two-axis rotor positioner with slew-rate limited motion.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as stream words on in_*: in_tuser carries the command
//   (tick, orient, jog azimuth, jog elevation, stop), in_tdata its operands.
//   Every command returns one status word on out_*: position, busy flags,
//   orientation phase and the stop flag, as seen after the command.
//   Slew rates are set through cfg_we/cfg_index/cfg_wdata while idle.
//   One word per cycle is sustained while out_tready is held high. Stage 1
//   forms speed * ms, stage 2 divides it by 1000 with a reciprocal multiply,
//   stage 3 updates the axis state into the output register. Each stage
//   moves when the next one is empty or moving, so a stalled receiver fills
//   the three stages before in_tready drops.
//   Synchronous reset clears positions, goals and flags to zero, the phase
//   to idle and both slew rates to 1000 centidegrees per second.
// ----------------------------------------------------------------------------
module dual_axis_slew_positioner import dasp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // az_target[15:0], el_target[31:16], delta[48:32], elapsed_ms[64:49]
  input  wire logic [71:0] in_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // az_pos[15:0], el_pos[29:16], az_busy[30], el_busy[31], phase[33:32],
  // user_stopped[34]
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [SPEED_W-1:0] az_speed_r, el_speed_r;
  logic               s1_valid_r, s1_valid_nxt, s2_valid_r, s2_valid_nxt;
  item_t              in_item, s1_item_r, s2_item_r;
  logic               ready2, ready3;
  pipe_ctl_t          ctl;
  logic [STEP_W-1:0]  az_step, el_step;
  res_t               out_res;

  assign in_item.cmd       = cmd_t'(in_tuser);
  assign in_item.az_target = in_tdata[15:0];
  assign in_item.el_target = $signed(in_tdata[31:16]);
  assign in_item.delta     = $signed(in_tdata[48:32]);

  assign ready3    = !out_tvalid || out_tready;
  assign ready2    = !s2_valid_r || ready3;
  assign in_tready = !s1_valid_r || ready2;

  assign ctl.s1_load  = in_tvalid && in_tready;
  assign ctl.s2_load  = s1_valid_r && ready2;
  assign ctl.out_load = s2_valid_r && ready3;

  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;
  assign s2_valid_nxt = ready2 ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      az_speed_r <= SPEED_RESET;
      el_speed_r <= SPEED_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_AZ_SPEED: az_speed_r <= cfg_wdata;
          CFG_EL_SPEED: el_speed_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_item_r <= in_item;
    end
    if (ctl.s2_load) begin
      s2_item_r <= s1_item_r;
    end
  end

  dasp_step u_az_step (
    .clk   (clk),
    .ctl   (ctl),
    .speed (az_speed_r),
    .ms    (in_tdata[64:49]),
    .step  (az_step)
  );

  dasp_step u_el_step (
    .clk   (clk),
    .ctl   (ctl),
    .speed (el_speed_r),
    .ms    (in_tdata[64:49]),
    .step  (el_step)
  );

  dasp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .item       (s2_item_r),
    .az_step    (az_step),
    .el_step    (el_step),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .res        (out_res)
  );

  assign out_tdata = {5'b00000, out_res.user_stopped, out_res.phase, out_res.el_busy,
                      out_res.az_busy, out_res.el_pos, out_res.az_pos};

  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.user_stopped |->
      out_res.phase == PH_IDLE && !out_res.az_busy && !out_res.el_busy)
    else $error("stop flag set while motion is active");

  a_el_phase_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.phase == PH_EL |-> out_res.el_busy)
    else $error("waiting on elevation with elevation not busy");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_res.az_pos < 16'd36000 && out_res.el_pos <= 14'd9000)
    else $error("position out of range");

endmodule
`default_nettype wire

/* sim/dual_axis_slew_positioner_test.sv */
// ----------------------------------------------------------------------------
// dual_axis_slew_positioner_test
// Self-checking bench for the two-axis slew positioner. A short directed
// sequence covers field extremes, range wrap and clamp, the half-turn and
// near-goal snap cases and the unused commands. It is followed by random
// orient/jog episodes with tick trains at several slew-rate settings.
// Each status word is checked field by field against a cycle-free model of
// the rotor kept in a small scoreboard, under random sender and receiver
// stalls.
// ----------------------------------------------------------------------------
module dual_axis_slew_positioner_test;
  import dasp_pkg::*;

  localparam int AZ_TURN   = 36000;
  localparam int AZ_HALFT  = 18000;
  localparam int EL_TOP    = 9000;
  localparam int AZ_NEAR   = 5;
  localparam int QUIET_MAX = 3000;
  localparam int BLOCK_WORDS = 112;

  class slew_scoreboard;
    int unsigned az_rate, el_rate;
    int az_now, el_now, az_goal, el_goal, pend_az, pend_el;
    bit az_busy, el_busy, stopped;
    phase_t phase;
    res_t status_q[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      az_rate = 1000;
      el_rate = 1000;
      az_now = 0; el_now = 0; az_goal = 0; el_goal = 0; pend_az = 0; pend_el = 0;
      az_busy = 0; el_busy = 0; stopped = 0;
      phase = PH_IDLE;
    endfunction

    function void set_rate(logic idx, int unsigned v);
      if (idx == CFG_AZ_SPEED) az_rate = v & 16'hFFFF;
      else el_rate = v & 16'hFFFF;
    endfunction

    function int wrap_az(longint a);
      longint r;
      r = a % AZ_TURN;
      if (r < 0) r += AZ_TURN;
      return int'(r);
    endfunction

    function int clamp_el(longint e);
      if (e < 0) return 0;
      if (e > EL_TOP) return EL_TOP;
      return int'(e);
    endfunction

    // shortest signed path to the azimuth goal; a half turn keeps the sign of goal - now
    function int az_offset();
      int d;
      d = az_goal - az_now;
      if (d > AZ_HALFT) d -= AZ_TURN;
      if (d < -AZ_HALFT) d += AZ_TURN;
      return d;
    endfunction

    function void begin_azimuth();
      int d;
      stopped = 0;
      az_goal = pend_az;
      d = az_offset();
      if (d <= AZ_NEAR && d >= -AZ_NEAR) begin
        az_now = az_goal;
        az_busy = 0;
      end else begin
        az_busy = 1;
      end
    endfunction

    function void aim(longint az, longint el);
      stopped = 0;
      pend_az = wrap_az(az);
      pend_el = clamp_el(el);
      el_goal = pend_el;
      el_busy = 1;
      phase = PH_EL;
    endfunction

    function void advance(int unsigned ms);
      longint az_step, el_step, mag;
      int d;
      az_step = (longint'(az_rate) * ms) / 1000;
      el_step = (longint'(el_rate) * ms) / 1000;
      d = az_offset();
      mag = (d < 0) ? -longint'(d) : longint'(d);
      if (mag <= az_step) begin
        az_now = az_goal;
        az_busy = 0;
      end else begin
        az_now = wrap_az(longint'(az_now) + ((d > 0) ? az_step : -az_step));
      end
      d = el_goal - el_now;
      mag = (d < 0) ? -longint'(d) : longint'(d);
      if (mag <= el_step) begin
        el_now = el_goal;
        el_busy = 0;
      end else begin
        el_now = clamp_el(longint'(el_now) + ((d > 0) ? el_step : -el_step));
      end
      // one phase transition per tick at most
      if (phase == PH_EL) begin
        if (!el_busy) begin
          begin_azimuth();
          phase = PH_AZ;
        end
      end else if (phase == PH_AZ) begin
        if (!az_busy) phase = PH_IDLE;
      end else begin
        phase = PH_IDLE;
      end
    endfunction

    function void note_command(logic [2:0] code, logic [15:0] az_t,
                               logic signed [15:0] el_t, logic signed [16:0] dl,
                               logic [15:0] ms);
      longint base_az, base_el;
      res_t e;
      base_az = (phase != PH_IDLE) ? pend_az : az_now;
      base_el = (phase != PH_IDLE) ? pend_el : el_now;
      case (code)
        CMD_TICK:   advance(ms);
        CMD_ORIENT: aim(longint'(az_t), longint'(el_t));
        CMD_JOG_AZ: aim(base_az + longint'(dl), base_el);
        CMD_JOG_EL: aim(base_az, base_el + longint'(dl));
        CMD_STOP: begin
          stopped = 1;
          az_busy = 0;
          el_busy = 0;
          phase = PH_IDLE;
          az_goal = az_now;
          el_goal = el_now;
        end
        default: ;
      endcase
      e.az_pos = az_now[AZ_W-1:0];
      e.el_pos = el_now[EL_W-1:0];
      e.az_busy = az_busy;
      e.el_busy = el_busy;
      e.phase = phase;
      e.user_stopped = stopped;
      status_q.push_back(e);
    endfunction

    function void check_status(logic [39:0] word);
      res_t got, exp;
      got = res_t'(word[34:0]);
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected status word %h", word);
        return;
      end
      exp = status_q.pop_front();
      if (got.az_pos !== exp.az_pos || got.el_pos !== exp.el_pos ||
          got.az_busy !== exp.az_busy || got.el_busy !== exp.el_busy ||
          got.phase !== exp.phase || got.user_stopped !== exp.user_stopped) begin
        errors++;
        if (errors <= 10)
          $display("status mismatch: az %0d/%0d el %0d/%0d busy %b%b/%b%b ph %0d/%0d stop %b/%b",
                   exp.az_pos, got.az_pos, exp.el_pos, got.el_pos,
                   exp.az_busy, exp.el_busy, got.az_busy, got.el_busy,
                   exp.phase, got.phase, exp.user_stopped, got.user_stopped);
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  slew_scoreboard sb = new();
  int tx_idle_pct = 7;
  int rx_stall_pct = 63;
  bit rx_hold_req = 1'b0;
  int words_sent = 0;
  int quiet = 0;

  dual_axis_slew_positioner dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_MAX);
        $display("dual_axis_slew_positioner_test NOT OK");
        $finish;
      end
    end
  end

  task automatic send_word(logic [2:0] code, logic [15:0] az, logic [15:0] el,
                           logic [16:0] dl, logic [15:0] ms);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= code;
    in_tdata <= {7'd0, ms, dl, el, az};
    do @(posedge clk); while (!in_tready);
    sb.note_command(code, az, el, dl, ms);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rates(int unsigned az_v, int unsigned el_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AZ_SPEED;
    cfg_wdata <= az_v[15:0];
    @(posedge clk);
    sb.set_rate(CFG_AZ_SPEED, az_v);
    cfg_index <= CFG_EL_SPEED;
    cfg_wdata <= el_v[15:0];
    @(posedge clk);
    sb.set_rate(CFG_EL_SPEED, el_v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_ms();
    int p;
    p = $urandom_range(99);
    if (p < 75) return 16'($urandom_range(0, 300));
    if (p < 95) return 16'($urandom_range(0, 4000));
    return 16'($urandom);
  endfunction

  function automatic logic [16:0] pick_delta();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 17'($urandom_range(0, 4000) - 2000);
    if (p < 88) return 17'($urandom_range(0, 72000) - 36000);
    return 17'($urandom);
  endfunction

  task automatic random_episode();
    int p, n;
    logic [15:0] az, el;
    p = $urandom_range(99);
    if (p < 70) begin
      case ($urandom_range(2))
        0: begin
          az = ($urandom_range(99) < 85) ? 16'($urandom_range(0, AZ_TURN - 1)) :
               16'($urandom);
          el = ($urandom_range(99) < 80) ? 16'($urandom_range(0, EL_TOP)) :
               (($urandom_range(1)) ? 16'($urandom) :
                16'($urandom_range(0, 27000) - 9000));
          send_word(CMD_ORIENT, az, el, 17'($urandom), 16'($urandom));
        end
        1: send_word(CMD_JOG_AZ, 16'($urandom), 16'($urandom), pick_delta(),
                     16'($urandom));
        default: send_word(CMD_JOG_EL, 16'($urandom), 16'($urandom), pick_delta(),
                           16'($urandom));
      endcase
      n = $urandom_range(2, 10);
      repeat (n) send_word(CMD_TICK, 16'($urandom), 16'($urandom), 17'($urandom),
                           pick_ms());
    end else if (p < 78) begin
      send_word(CMD_STOP, 16'($urandom), 16'($urandom), 17'($urandom), 16'($urandom));
    end else if (p < 82) begin
      send_word(3'($urandom_range(CMD_STOP + 1, 7)), 16'($urandom), 16'($urandom),
                17'($urandom), 16'($urandom));
    end else begin
      // noise: every field random, including the command
      send_word(3'($urandom), 16'($urandom), 16'($urandom), 17'($urandom),
                16'($urandom));
    end
  endtask

  initial begin
    int unsigned az_v, el_v;
    int stop_at;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_TICK, 0, 0, 0, 0);
    send_word(CMD_ORIENT, 9000, 4500, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    // out-of-range targets: azimuth reduced, elevation clamped low then high
    send_word(CMD_ORIENT, 16'hFFFF, 16'(-9000), 0, 0);
    send_word(CMD_ORIENT, 35999, 18000, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 1000);
    send_word(CMD_STOP, 0, 0, 0, 0);
    send_word(CMD_JOG_AZ, 0, 0, 36000, 0);
    send_word(CMD_JOG_AZ, 0, 0, 17'(-36000), 0);
    send_word(CMD_JOG_EL, 0, 0, 17'h0FFFF, 0);
    send_word(CMD_JOG_EL, 0, 0, 17'h10000, 0);
    // home, then a half-turn move
    send_word(CMD_ORIENT, 0, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_word(CMD_ORIENT, 18000, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_word(CMD_TICK, 0, 0, 0, 100);
    // azimuth within the snap window of its start
    send_word(CMD_ORIENT, 105, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_word(CMD_TICK, 0, 0, 0, 0);
    // short path backwards through zero
    send_word(CMD_ORIENT, 35900, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_word(CMD_TICK, 0, 0, 0, 150);
    send_word(CMD_TICK, 0, 0, 0, 16'hFFFF);
    for (int c = CMD_STOP + 1; c < 8; c++)
      send_word(3'(c), 16'($urandom), 16'($urandom), 17'($urandom), 16'($urandom));

    for (int blk = 0; blk < 6; blk++) begin
      drain();
      case (blk)
        0: begin az_v = 65535; el_v = 65535; end
        1: begin az_v = 0; el_v = 65535; end
        2: begin az_v = 1; el_v = 0; end
        5: begin az_v = 1000; el_v = 1000; end
        default: begin az_v = $urandom_range(50, 3000); el_v = $urandom_range(50, 3000); end
      endcase
      set_rates(az_v, el_v);
      tx_idle_pct = (blk < 2) ? 7 : (blk < 4) ? 63 : 0;
      rx_stall_pct = (blk < 2) ? 63 : (blk < 4) ? 7 : 0;
      stop_at = words_sent + BLOCK_WORDS;
      if (blk == 4) begin
        repeat (3) random_episode();
        // hold the receiver while words keep coming so the pipe backs up
        rx_hold_req = 1'b1;
      end
      while (words_sent < stop_at) random_episode();
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("dual_axis_slew_positioner_test OK");
    else
      $display("dual_axis_slew_positioner_test NOT OK");
    $finish;
  end

endmodule
